### design/ale_pkg.sv
package ale_pkg;

	// Store depth used when the top level is not told otherwise
	localparam int DEPTH_DEF = 16;

	// Capacity after reset
	localparam logic [4:0] CAP_RESET = 5'd16;

	// Configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;

	// Word that fills a free slot of the store
	localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ACT_APPEND  = 3'd0,
		ACT_INSERT  = 3'd1,
		ACT_DEL_AT  = 3'd2,
		ACT_DEL_VAL = 3'd3,
		ACT_FIND    = 3'd4,
		ACT_READ    = 3'd5,
		ACT_CLEAR   = 3'd6,
		ACT_NOP     = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [3:0]         found_position;
		logic signed [31:0] read_word;
		logic [4:0]         count;
	} rsp_t;

endpackage

### design/ale_ram.sv
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/array_list_engine.sv
// Clear, no-op and any refused request go straight to the response; append
// writes the entry and read reads the store; insert shifts the tail up first
// unless at the end, delete at shifts it down first unless at the last entry,
// and find and delete value scan from the head first. Throughput: one request
// at a time; the store read port walks one entry per cycle.
// Reset: fill count 0, capacity 16, response empty; no clearing pass, since
// only entries below the fill count are ever read.
module array_list_engine #(
	parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// request channel
	input  logic          req_valid,
	output logic          req_ready,
	input  ale_pkg::req_t req,
	// response channel
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ale_pkg::rsp_t rsp,
	// configuration port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 4) ? CW : 4;
	localparam int YW = (CW > 5) ? CW : 5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_UP,
		S_DN,
		S_PUT,
		S_TAIL,
		S_RD,
		S_RDW,
		S_DONE
	} state_t;

	state_t             state_q;
	ale_pkg::action_t   act_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      idx_q;
	logic               more_q;
	logic               pend_s1;
	logic [AW-1:0]      ix_s1;
	logic [AW-1:0]      wa_s1;
	logic [CW-1:0]      fc_q;
	logic [4:0]         cap_q;
	ale_pkg::status_t   st_q;
	logic [3:0]         found_q;
	logic [31:0]        rdw_q;
	logic               rsp_valid_q;
	ale_pkg::rsp_t      rsp_q;

	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic [31:0]        ram_wr_data;
	logic               ram_rd_en;
	logic [31:0]        ram_rd_data;

	logic [CW-1:0]      fc_m1;
	logic [AW-1:0]      last_idx;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      fc_x;
	logic               full;
	logic               hit;
	logic               cfg_wr;

	// Decode limits and positions
	assign fc_m1    = fc_q - CW'(1);
	assign last_idx = AW'(fc_m1);
	assign pos_x    = XW'(req.position);
	assign fc_x     = XW'(fc_q);
	assign full     = (fc_q == CW'(DEPTH)) || (YW'(fc_q) >= YW'(cap_q));
	assign hit      = (state_q == S_SCAN) && pend_s1 && (ram_rd_data == val_q);

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == ale_pkg::REG_CAPACITY) ? 32'(cap_q) : '0;

	// Handshake and response
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Drive the store ports from the sequencer
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wa_s1;
		ram_wr_data = ram_rd_data;
		unique case (state_q)
			S_SCAN: begin
				ram_rd_en = more_q;
			end
			S_UP, S_DN: begin
				ram_rd_en = more_q;
				ram_wr_en = pend_s1;
			end
			S_PUT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = pos_q;
				ram_wr_data = val_q;
			end
			S_TAIL: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = last_idx;
				ram_wr_data = ale_pkg::EMPTY_WORD;
			end
			S_RD: begin
				ram_rd_en = 1'b1;
			end
			default: begin
				ram_rd_en = 1'b0;
			end
		endcase
	end

	ale_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	// Sequencer, fill count, capacity and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ale_pkg::ACT_NOP;
			val_q       <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			more_q      <= 1'b0;
			pend_s1     <= 1'b0;
			ix_s1       <= '0;
			wa_s1       <= '0;
			fc_q        <= '0;
			cap_q       <= ale_pkg::CAP_RESET;
			st_q        <= ale_pkg::ST_OK;
			found_q     <= '0;
			rdw_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// drop the response word once taken, unless a new one replaces it
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr[2] == ale_pkg::REG_CAPACITY) begin
				cap_q <= pwdata[4:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q   <= req.action;
						val_q   <= req.value;
						st_q    <= ale_pkg::ST_OK;
						found_q <= '0;
						rdw_q   <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
						unique case (req.action)
							ale_pkg::ACT_APPEND: begin
								if (full) begin
									st_q <= ale_pkg::ST_FULL;
								end else begin
									pos_q   <= AW'(fc_q);
									state_q <= S_PUT;
								end
							end
							ale_pkg::ACT_INSERT: begin
								if (pos_x > fc_x) begin
									st_q <= ale_pkg::ST_RANGE;
								end else if (full) begin
									st_q <= ale_pkg::ST_FULL;
								end else if (pos_x == fc_x) begin
									pos_q   <= AW'(fc_q);
									state_q <= S_PUT;
								end else begin
									pos_q   <= AW'(req.position);
									idx_q   <= last_idx;
									more_q  <= 1'b1;
									state_q <= S_UP;
								end
							end
							ale_pkg::ACT_DEL_AT: begin
								if (pos_x >= fc_x) begin
									st_q <= ale_pkg::ST_RANGE;
								end else if (pos_x == XW'(fc_m1)) begin
									state_q <= S_TAIL;
								end else begin
									idx_q   <= AW'(req.position) + AW'(1);
									more_q  <= 1'b1;
									state_q <= S_DN;
								end
							end
							ale_pkg::ACT_DEL_VAL, ale_pkg::ACT_FIND: begin
								if (fc_q == '0) begin
									st_q <= ale_pkg::ST_NOT_FOUND;
								end else begin
									idx_q   <= '0;
									more_q  <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							ale_pkg::ACT_READ: begin
								if (pos_x >= fc_x) begin
									st_q <= ale_pkg::ST_RANGE;
								end else begin
									idx_q   <= AW'(req.position);
									state_q <= S_RD;
								end
							end
							ale_pkg::ACT_CLEAR: begin
								fc_q <= '0;
							end
							default: begin
								st_q <= ale_pkg::ST_OK;
							end
						endcase
					end
				end
				// walk the list from the head, compare one entry behind the read
				S_SCAN: begin
					pend_s1 <= more_q;
					ix_s1   <= idx_q;
					if (more_q) begin
						if (idx_q == last_idx) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
					if (hit) begin
						more_q  <= 1'b0;
						pend_s1 <= 1'b0;
						if (act_q == ale_pkg::ACT_FIND) begin
							found_q <= 4'(ix_s1);
							state_q <= S_DONE;
						end else if (ix_s1 == last_idx) begin
							state_q <= S_TAIL;
						end else begin
							idx_q   <= ix_s1 + AW'(1);
							more_q  <= 1'b1;
							state_q <= S_DN;
						end
					end else if (!more_q && !pend_s1) begin
						st_q    <= ale_pkg::ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				// shift the tail up one place, last entry first
				S_UP: begin
					pend_s1 <= more_q;
					wa_s1   <= idx_q + AW'(1);
					if (more_q) begin
						if (idx_q == pos_q) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end
					if (!more_q && !pend_s1) begin
						state_q <= S_PUT;
					end
				end
				// shift the tail down one place, first entry first
				S_DN: begin
					pend_s1 <= more_q;
					wa_s1   <= idx_q - AW'(1);
					if (more_q) begin
						if (idx_q == last_idx) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
					if (!more_q && !pend_s1) begin
						state_q <= S_TAIL;
					end
				end
				S_PUT: begin
					fc_q    <= fc_q + CW'(1);
					state_q <= S_DONE;
				end
				S_TAIL: begin
					fc_q    <= fc_m1;
					state_q <= S_DONE;
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					rdw_q   <= ram_rd_data;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the response register frees up
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q          <= 1'b1;
						rsp_q.status         <= st_q;
						rsp_q.found_position <= found_q;
						rsp_q.read_word      <= rdw_q;
						rsp_q.count          <= 5'(fc_q);
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CW'(DEPTH))
		else $error("fill count beyond store depth");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && ram_rd_en) |-> (ram_wr_addr != idx_q))
		else $error("store read and write hit the same entry");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one still in work");
`endif

endmodule

### sim/list_response_checker.sv
`timescale 1ns / 1ps
module list_response_checker #(
	parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  ale_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  ale_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	input  logic          pready,
	output int            fail_count,
	output int            pending
);

	// Shadow copy of the list, its length and the capacity register
	logic [31:0]   words [DEPTH];
	int            len;
	logic [4:0]    cap_now;
	ale_pkg::rsp_t expected_q [$];

	// Return the first position holding key, or -1
	function automatic int first_hit(input logic [31:0] key);
		int i;
		for (i = 0; i < len; i++) begin
			if (words[i] == key)
				return i;
		end
		return -1;
	endfunction

	// Close the gap at pos and free the last slot
	function automatic void drop_at(input int pos);
		int i;
		for (i = pos; i + 1 < len; i++)
			words[i] = words[i + 1];
		words[len - 1] = ale_pkg::EMPTY_WORD;
		len--;
	endfunction

	// Apply one request to the shadow list and build the word it returns
	function automatic ale_pkg::rsp_t apply_request(input ale_pkg::req_t r);
		ale_pkg::rsp_t o;
		int            lim;
		int            pos;
		int            hit;
		int            i;
		o = '0;
		lim = (int'(cap_now) > DEPTH) ? DEPTH : int'(cap_now);
		pos = int'(r.position);
		case (r.action)
			ale_pkg::ACT_APPEND: begin
				if (len >= lim)
					o.status = ale_pkg::ST_FULL;
				else begin
					words[len] = r.value;
					len++;
				end
			end
			ale_pkg::ACT_INSERT: begin
				if (pos > len)
					o.status = ale_pkg::ST_RANGE;
				else if (len >= lim)
					o.status = ale_pkg::ST_FULL;
				else begin
					for (i = len; i > pos; i--)
						words[i] = words[i - 1];
					words[pos] = r.value;
					len++;
				end
			end
			ale_pkg::ACT_DEL_AT: begin
				if (pos >= len)
					o.status = ale_pkg::ST_RANGE;
				else
					drop_at(pos);
			end
			ale_pkg::ACT_DEL_VAL: begin
				hit = first_hit(r.value);
				if (hit < 0)
					o.status = ale_pkg::ST_NOT_FOUND;
				else
					drop_at(hit);
			end
			ale_pkg::ACT_FIND: begin
				hit = first_hit(r.value);
				if (hit < 0)
					o.status = ale_pkg::ST_NOT_FOUND;
				else
					o.found_position = 4'(hit);
			end
			ale_pkg::ACT_READ: begin
				if (pos >= len)
					o.status = ale_pkg::ST_RANGE;
				else
					o.read_word = words[pos];
			end
			ale_pkg::ACT_CLEAR: begin
				for (i = 0; i < DEPTH; i++)
					words[i] = ale_pkg::EMPTY_WORD;
				len = 0;
			end
			default: ;
		endcase
		o.count = 5'(len);
		return o;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0.1f ns: mismatch on %s: got %0h, expected %0h",
			$realtime, what, got, want);
		fail_count++;
	endtask

	// Track configuration, predict on each request word, compare each response word
	always @(posedge clk or negedge arst_n) begin
		ale_pkg::rsp_t want;
		int            i;
		if (!arst_n) begin
			for (i = 0; i < DEPTH; i++)
				words[i] = ale_pkg::EMPTY_WORD;
			len = 0;
			cap_now = ale_pkg::CAP_RESET;
			expected_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr == 3'(4 * ale_pkg::REG_CAPACITY))
				cap_now = pwdata[4:0];
			if (req_valid && req_ready)
				expected_q.push_back(apply_request(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0)
					report_mismatch("response word with none pending", 64'(rsp), '0);
				else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.found_position !== want.found_position)
						report_mismatch("found_position", 64'(rsp.found_position),
							64'(want.found_position));
					if (rsp.read_word !== want.read_word)
						report_mismatch("read_word", 64'(rsp.read_word),
							64'(want.read_word));
					if (rsp.count !== want.count)
						report_mismatch("count", 64'(rsp.count), 64'(want.count));
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

### sim/array_list_engine_tb.sv
`timescale 1ns / 1ps
module array_list_engine_tb;

	localparam int HOLD_CYCLES     = 200;
	localparam int STALL_LIMIT     = 2000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int PHASES          = 9;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	ale_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	ale_pkg::rsp_t rsp;
	logic          psel      = 1'b0;
	logic          penable   = 1'b0;
	logic          pwrite    = 1'b0;
	logic [2:0]    paddr     = '0;
	logic [31:0]   pwdata    = '0;
	logic [31:0]   prdata;
	logic          pready;
	int            fail_count;
	int            pending;

	bit quiet       = 1'b0;
	int hold_asked  = 0;
	int hold_taken  = 0;
	int hold_left   = 0;
	int burst_left  = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	array_list_engine u_top (.*);

	list_response_checker u_check (.*);

	// Drive response ready: long hold-off on request, short random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else if (burst_left > 0) begin
			rsp_ready <= 1'b0;
			burst_left--;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			burst_left = $urandom_range(0, 2);
			rsp_ready <= 1'b0;
		end else
			rsp_ready <= 1'b1;
	end

	// Abort when no word moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Offer one request word, maybe after a short gap, and hold it until taken
	task automatic send_request(input ale_pkg::req_t r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_op(input ale_pkg::action_t act, input logic [31:0] val,
			input logic [3:0] pos);
		ale_pkg::req_t r;
		r.action = act;
		r.value = val;
		r.position = pos;
		send_request(r);
	endtask

	// Stop offering and wait until every response word has come back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write the capacity register with the list idle
	task automatic write_capacity(input logic [4:0] cap);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * ale_pkg::REG_CAPACITY);
		pwdata <= 32'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Pick a random request; grow favors adds so the list fills up
	function automatic ale_pkg::req_t random_request(input bit grow);
		ale_pkg::req_t r;
		int            pick;
		pick = $urandom_range(0, 99);
		if (grow)
			r.action = pick < 40 ? ale_pkg::ACT_APPEND :
				pick < 65 ? ale_pkg::ACT_INSERT :
				pick < 72 ? ale_pkg::ACT_DEL_AT :
				pick < 78 ? ale_pkg::ACT_DEL_VAL :
				pick < 89 ? ale_pkg::ACT_FIND :
				pick < 98 ? ale_pkg::ACT_READ : ale_pkg::ACT_NOP;
		else
			r.action = pick < 22 ? ale_pkg::ACT_APPEND :
				pick < 38 ? ale_pkg::ACT_INSERT :
				pick < 52 ? ale_pkg::ACT_DEL_AT :
				pick < 64 ? ale_pkg::ACT_DEL_VAL :
				pick < 78 ? ale_pkg::ACT_FIND :
				pick < 92 ? ale_pkg::ACT_READ :
				pick < 96 ? ale_pkg::ACT_CLEAR : ale_pkg::ACT_NOP;
		// repeat a few common words so searches and deletes hit
		case ($urandom_range(0, 9))
			0: r.value = 32'h7FFF_FFFF;
			1: r.value = 32'h8000_0000;
			2: r.value = ale_pkg::EMPTY_WORD;
			3, 4, 5: r.value = 32'($urandom_range(0, 7));
			default: r.value = $urandom();
		endcase
		r.position = $urandom_range(0, 1) ? 4'($urandom_range(0, 4)) :
			4'($urandom_range(0, 15));
		return r;
	endfunction

	initial begin
		logic [4:0] caps [PHASES];
		int         phase;
		int         n;
		caps = '{5'd31, 5'd16, 5'd5, 5'd1, 5'd0, 5'd9, 5'd31, 5'd16, 5'd2};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, boundary words, shifts and searches at reset capacity
		send_op(ale_pkg::ACT_READ, 32'd0, 4'd0);
		send_op(ale_pkg::ACT_DEL_AT, 32'd0, 4'd0);
		send_op(ale_pkg::ACT_DEL_VAL, 32'd5, 4'd0);
		send_op(ale_pkg::ACT_FIND, 32'd5, 4'd0);
		send_op(ale_pkg::ACT_INSERT, 32'd1, 4'd1);
		send_op(ale_pkg::ACT_APPEND, 32'h7FFF_FFFF, 4'd0);
		send_op(ale_pkg::ACT_APPEND, 32'h8000_0000, 4'd15);
		send_op(ale_pkg::ACT_APPEND, ale_pkg::EMPTY_WORD, 4'd0);
		send_op(ale_pkg::ACT_INSERT, 32'd0, 4'd0);
		send_op(ale_pkg::ACT_INSERT, 32'd3, 4'd4);
		send_op(ale_pkg::ACT_FIND, ale_pkg::EMPTY_WORD, 4'd0);
		send_op(ale_pkg::ACT_READ, 32'd0, 4'd4);
		send_op(ale_pkg::ACT_DEL_VAL, 32'h8000_0000, 4'd0);
		send_op(ale_pkg::ACT_DEL_AT, 32'd0, 4'd0);
		send_op(ale_pkg::ACT_NOP, 32'hFFFF_FFFF, 4'd15);
		send_op(ale_pkg::ACT_CLEAR, 32'd0, 4'd0);
		send_op(ale_pkg::ACT_FIND, ale_pkg::EMPTY_WORD, 4'd0);

		// small capacity: full list, range check ahead of full check
		write_capacity(5'd2);
		send_op(ale_pkg::ACT_APPEND, 32'd11, 4'd0);
		send_op(ale_pkg::ACT_APPEND, 32'd22, 4'd0);
		send_op(ale_pkg::ACT_APPEND, 32'd33, 4'd0);
		send_op(ale_pkg::ACT_INSERT, 32'd44, 4'd3);
		send_op(ale_pkg::ACT_INSERT, 32'd44, 4'd1);

		// capacity lowered below the fill count
		write_capacity(5'd1);
		send_op(ale_pkg::ACT_APPEND, 32'd55, 4'd0);
		send_op(ale_pkg::ACT_DEL_AT, 32'd0, 4'd1);
		send_op(ale_pkg::ACT_APPEND, 32'd55, 4'd0);

		// zero capacity refuses every add
		write_capacity(5'd0);
		send_op(ale_pkg::ACT_INSERT, 32'd66, 4'd0);
		send_op(ale_pkg::ACT_DEL_AT, 32'd0, 4'd0);
		send_op(ale_pkg::ACT_APPEND, 32'd66, 4'd0);

		// random phases over several capacities, quiet in the last one
		for (phase = 0; phase < PHASES; phase++) begin
			write_capacity(caps[phase]);
			if (phase == 1)
				hold_asked <= hold_asked + 1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 25 == 0)
					quiet <= (phase == PHASES - 1) || ($urandom_range(0, 2) == 0);
				if (phase == 3 && n == 50)
					drain();
				send_request(random_request(phase % 2 == 0));
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
